/* src/rsi_pkg.sv */
// rsi_pkg: shared widths, constants and types for the ray/sphere intersect core
// no dependencies
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIR_W     = 18;
  localparam int DIST_W    = 31;
  localparam int OP_W      = COORD_W + 1;            // center - origin
  localparam int PROD_W    = OP_W + DIR_W;           // one dot term
  localparam int DOT_W     = PROD_W + 2;             // sum of three terms
  localparam int B_W       = DOT_W - FRAC_BITS;      // b after the shift
  localparam int SQ_OP_W   = 2 * OP_W;               // one op square
  localparam int NEG_W     = SQ_OP_W + 2;            // |op|^2
  localparam int RSQ_W     = 2 * DIST_W;             // radius^2
  localparam int D_W       = 2 * B_W;                // b^2 and discriminant
  localparam int SQ_W      = B_W;                    // square root bits
  localparam int TRIAL_W   = D_W + 2;                // sqrt trial value
  localparam int T_W       = B_W + 2;                // root candidates

  localparam logic signed [T_W-1:0] EPS =
    T_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } rsi_reg_t;

  localparam logic [DIST_W-1:0] RADIUS_RESET = DIST_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [DIST_W-1:0]  radius;
  } rsi_cfg_t;

  typedef struct packed {
    logic                  miss;
    logic signed [B_W-1:0] b;
    logic [D_W-1:0]        d;
  } rsi_disc_t;

endpackage

/* src/rsi_cfg.sv */
// rsi_cfg: apb register file holding the sphere center and radius
// depends on rsi_pkg
`timescale 1ns / 1ps
module rsi_cfg
  import rsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rsi_cfg_t          cfg
);

  logic     wr;
  rsi_reg_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = rsi_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.center_z <= '0;
      cfg.radius   <= RADIUS_RESET;
    end else if (wr) begin
      case (idx)
        REG_CENTER_X: cfg.center_x <= pwdata;
        REG_CENTER_Y: cfg.center_y <= pwdata;
        REG_CENTER_Z: cfg.center_z <= pwdata;
        REG_RADIUS:   cfg.radius   <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = cfg.center_x;
      REG_CENTER_Y: prdata = cfg.center_y;
      REG_CENTER_Z: prdata = cfg.center_z;
      REG_RADIUS:   prdata = {1'b0, cfg.radius};
      default:      prdata = '0;
    endcase
  end

endmodule

/* src/rsi_front.sv */
// rsi_front: five stages forming b and the discriminant of one ray
// depends on rsi_pkg
`timescale 1ns / 1ps
module rsi_front
  import rsi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic signed [COORD_W-1:0] origin_z,
  input  logic signed [DIR_W-1:0]   dir_x,
  input  logic signed [DIR_W-1:0]   dir_y,
  input  logic signed [DIR_W-1:0]   dir_z,
  input  rsi_cfg_t                  cfg,
  output logic                      out_valid,
  output rsi_disc_t                 out_data
);

  // stage 1: op = center - origin
  logic                   v1;
  logic signed [OP_W-1:0] ox1, oy1, oz1;
  logic signed [DIR_W-1:0] dx1, dy1, dz1;
  logic [DIST_W-1:0]      r1;
  // stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] px2, py2, pz2;
  logic [SQ_OP_W-1:0]       sx2, sy2, sz2;
  logic [RSQ_W-1:0]         rsq2;
  // stage 3: sums
  logic                  v3;
  logic signed [B_W-1:0] b3;
  logic [NEG_W-1:0]      neg3;
  logic [RSQ_W-1:0]      rsq3;
  logic signed [DOT_W-1:0] dot;
  // stage 4: b squared
  logic                  v4;
  logic signed [B_W-1:0] b4;
  logic [D_W-1:0]        bsq4;
  logic [NEG_W-1:0]      neg4;
  logic [RSQ_W-1:0]      rsq4;
  logic [B_W-1:0]        bmag;
  // stage 5 compare
  logic [D_W:0]          pos;

  assign dot  = DOT_W'(px2) + DOT_W'(py2) + DOT_W'(pz2);
  assign bmag = b3[B_W-1] ? B_W'(-b3) : B_W'(b3);
  assign pos  = (D_W+1)'(bsq4) + (D_W+1)'(rsq4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox1  <= OP_W'(cfg.center_x) - OP_W'(origin_x);
      oy1  <= OP_W'(cfg.center_y) - OP_W'(origin_y);
      oz1  <= OP_W'(cfg.center_z) - OP_W'(origin_z);
      dx1  <= dir_x;
      dy1  <= dir_y;
      dz1  <= dir_z;
      r1   <= cfg.radius;

      px2  <= PROD_W'(ox1 * dx1);
      py2  <= PROD_W'(oy1 * dy1);
      pz2  <= PROD_W'(oz1 * dz1);
      sx2  <= SQ_OP_W'(ox1 * ox1);
      sy2  <= SQ_OP_W'(oy1 * oy1);
      sz2  <= SQ_OP_W'(oz1 * oz1);
      rsq2 <= RSQ_W'(r1 * r1);

      // arithmetic shift rounds toward minus infinity
      b3   <= B_W'(dot >>> FRAC_BITS);
      neg3 <= NEG_W'(sx2) + NEG_W'(sy2) + NEG_W'(sz2);
      rsq3 <= rsq2;

      b4   <= b3;
      bsq4 <= D_W'(bmag * bmag);
      neg4 <= neg3;
      rsq4 <= rsq3;

      out_data.b    <= b4;
      out_data.miss <= pos < (D_W+1)'(neg4);
      out_data.d    <= D_W'(pos - (D_W+1)'(neg4));
    end
  end

endmodule

/* src/rsi_sqrt.sv */
// rsi_sqrt: pipelined integer square root, one result bit per stage
// depends on rsi_pkg
`timescale 1ns / 1ps
module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  rsi_disc_t             in_data,
  output logic                  out_valid,
  output logic                  out_miss,
  output logic signed [B_W-1:0] out_b,
  output logic [SQ_W-1:0]       out_root
);

  logic                  vld  [SQ_W];
  logic                  miss [SQ_W];
  logic signed [B_W-1:0] bq   [SQ_W];
  logic [D_W-1:0]        rem  [SQ_W];
  logic [SQ_W-1:0]       root [SQ_W];

  for (genvar i = 0; i < SQ_W; i++) begin : g_stage
    localparam int K = SQ_W - 1 - i;
    logic                  vin, min;
    logic signed [B_W-1:0] bin;
    logic [D_W-1:0]        rin;
    logic [SQ_W-1:0]       yin;
    logic [TRIAL_W-1:0]    trial;
    logic                  take;

    if (i == 0) begin : g_first
      assign vin = in_valid;
      assign min = in_data.miss;
      assign bin = in_data.b;
      assign rin = in_data.d;
      assign yin = '0;
    end else begin : g_next
      assign vin = vld[i-1];
      assign min = miss[i-1];
      assign bin = bq[i-1];
      assign rin = rem[i-1];
      assign yin = root[i-1];
    end

    // (y + 2^k)^2 - y^2
    assign trial = (TRIAL_W'(yin) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
    assign take  = TRIAL_W'(rin) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        miss[i] <= min;
        bq[i]   <= bin;
        rem[i]  <= take ? D_W'(TRIAL_W'(rin) - trial) : rin;
        root[i] <= take ? (yin | (SQ_W'(1) << K)) : yin;
      end
    end
  end

  assign out_valid = vld[SQ_W-1];
  assign out_miss  = miss[SQ_W-1];
  assign out_b     = bq[SQ_W-1];
  assign out_root  = root[SQ_W-1];

endmodule

/* src/ray_sphere_intersect_core.sv */
// ray_sphere_intersect_core: top level, ray stream in, hit distance stream out
// depends on rsi_pkg, rsi_cfg, rsi_front, rsi_sqrt
`timescale 1ns / 1ps
// one ray enters per clock whenever the pipeline advances: five stages
// form b = (center - origin) . dir and the discriminant, 37 stages take the
// square root one bit each, and one stage picks the root and saturates into
// the output register. the whole pipeline advances together whenever the
// output register is empty or being taken, so throughput is one item per
// cycle while the sink keeps up. sphere center and radius come from the apb
// registers and should only change while no ray is in flight.
module ray_sphere_intersect_core
  import rsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // apb configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // ray input
  input  logic              s_tvalid,
  output logic              s_tready,
  // origin_x[31:0] origin_y[63:32] origin_z[95:64]
  // dir_x[113:96] dir_y[131:114] dir_z[149:132], rest zero
  input  logic [151:0]      s_tdata,
  // result output
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // hit_distance[30:0], bit 31 zero
  output logic              m_tuser    // hit
);

  rsi_cfg_t  cfg;
  logic      en;
  logic      f_valid;
  rsi_disc_t f_data;
  logic                  q_valid, q_miss;
  logic signed [B_W-1:0] q_b;
  logic [SQ_W-1:0]       q_root;

  logic signed [T_W-1:0] near_t, far_t, pick_t;
  logic                  found;
  logic [DIST_W-1:0]     hit_dist;

  // whole pipeline moves when the output slot frees up
  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en;

  rsi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  rsi_front u_front (
    .clk, .rst, .en,
    .in_valid  (s_tvalid),
    .origin_x  (s_tdata[31:0]),
    .origin_y  (s_tdata[63:32]),
    .origin_z  (s_tdata[95:64]),
    .dir_x     (s_tdata[113:96]),
    .dir_y     (s_tdata[131:114]),
    .dir_z     (s_tdata[149:132]),
    .cfg,
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  rsi_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_miss  (q_miss),
    .out_b     (q_b),
    .out_root  (q_root)
  );

  // nearer root first, farther root if the near one is behind epsilon
  assign near_t = T_W'(q_b) - $signed(T_W'(q_root));
  assign far_t  = T_W'(q_b) + $signed(T_W'(q_root));

  always_comb begin
    found  = 1'b0;
    pick_t = '0;
    if (!q_miss) begin
      if (near_t > EPS) begin
        found  = 1'b1;
        pick_t = near_t;
      end else if (far_t > EPS) begin
        found  = 1'b1;
        pick_t = far_t;
      end
    end
    if (!found) begin
      hit_dist = '0;
    end else if (pick_t > $signed(T_W'(DIST_MAX))) begin
      hit_dist = DIST_MAX;
    end else begin
      hit_dist = pick_t[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, hit_dist};
      m_tuser <= found;
    end
  end

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero distance");

  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    s_tready == (m_tready || !m_tvalid))
    else $error("input ready out of step with output slot");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(q_valid) && $stable(q_root))
    else $error("sqrt pipeline moved while stalled");
`endif

endmodule
